// ===== design/pcapx_pkg.sv =====
// Shared types and constants for the pcap UDP payload extractor.
package pcapx_pkg;

	typedef enum logic [1:0] {
		PH_GLOBAL = 2'd0,
		PH_RECHDR = 2'd1,
		PH_DATA   = 2'd2,
		PH_HALT   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_EMPTY   = 3'd1,
		KIND_DISCARD = 3'd2,
		KIND_SUBST   = 3'd3,
		KIND_HALT    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CODE_SHORT    = 3'd0,
		CODE_NOT_IPV4 = 3'd1,
		CODE_NOT_UDP  = 3'd2,
		CODE_BAD_IHL  = 3'd3,
		CODE_NOT_ETH  = 3'd4,
		CODE_NO_PRIOR = 3'd5
	} code_t;

	// one result from the parser to the output register
	typedef struct packed {
		logic       vld;
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		code_t      code;
	} result_t;

	localparam int GLOBAL_LAST  = 23;   // last byte of the global header
	localparam int RECHDR_LAST  = 15;   // last byte of a record header
	localparam int CAPLEN_FIRST = 8;    // captured length, bytes 8..11
	localparam int CAPLEN_LAST  = 11;
	localparam int OFF_ETYPE_HI = 12;
	localparam int OFF_ETYPE_LO = 13;
	localparam int OFF_IP_VIHL  = 14;
	localparam int OFF_IP_PROTO = 23;
	localparam int OFF_UDP_HI   = 38;
	localparam int OFF_UDP_LO   = 39;
	localparam int OFF_EMPTY    = 41;
	localparam int OFF_PAYLOAD  = 42;
	localparam int MIN_LEN_ETH  = 14;
	localparam int MIN_LEN_IP   = 34;
	localparam int UDP_HDR_LEN  = 8;

	localparam logic [31:0] LINKTYPE_ETH = 32'd1;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0008; // as read little-endian
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [3:0]  IHL_PLAIN    = 4'd5;
	localparam logic [16:0] LIMIT_RESET  = 17'd65536;

endpackage

// ===== design/pcapx_parser.sv =====
// Per-byte pcap / Ethernet / IPv4 / UDP parser state and next-state logic.
module pcapx_parser #(
	parameter int LENGTH_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          file_byte,
	input  logic                restart,
	input  logic [16:0]         length_limit,
	output pcapx_pkg::result_t  res
);
	import pcapx_pkg::*;

	localparam int LW = LENGTH_BITS;
	localparam int CW = (LW > 16) ? LW : 16;

	phase_t          phase_q, phase_c, phase_d;
	logic [LW-1:0]   off_q, off_c, off_d;
	logic [LW-1:0]   rlen_q, rlen_c, rlen_d;
	logic [LW-1:0]   lgood_q, lgood_c, lgood_d;
	logic [31:0]     hw_q, hw_c, hw_d;
	logic [7:0]      udp_hi_q, udp_hi_c, udp_hi_d;
	logic            ok_q, ok_c, ok_d;
	logic [LW-1:0]   pend_q, pend_c, pend_d;

	// restart drops all state before the byte is looked at
	always_comb begin
		if (restart) begin
			phase_c  = PH_GLOBAL;
			off_c    = '0;
			rlen_c   = '0;
			lgood_c  = '0;
			hw_c     = '0;
			udp_hi_c = '0;
			ok_c     = 1'b0;
			pend_c   = '0;
		end else begin
			phase_c  = phase_q;
			off_c    = off_q;
			rlen_c   = rlen_q;
			lgood_c  = lgood_q;
			hw_c     = hw_q;
			udp_hi_c = udp_hi_q;
			ok_c     = ok_q;
			pend_c   = pend_q;
		end
	end

	logic [31:0]   hw_shift, hw_hdr, lim32, ll32, mask32;
	logic          glob_last, glob_bad, hdr_cap, hdr_last, over, no_prior;
	logic [LW-1:0] new_rlen;
	logic [LW:0]   o_inc;
	logic          rec_end, rec_last, type_bad, in_pay, pay_last;
	logic [15:0]   udp_full, cnt16;
	logic [CW-1:0] cnt_w, avail_w, clip_w;
	logic [LW-1:0] pend_new;

	assign hw_shift  = {file_byte, hw_c[31:8]};
	assign glob_last = (off_c == LW'(GLOBAL_LAST));
	assign glob_bad  = (hw_shift != LINKTYPE_ETH);
	assign hdr_cap   = (off_c >= LW'(CAPLEN_FIRST)) && (off_c <= LW'(CAPLEN_LAST));
	assign hw_hdr    = hdr_cap ? hw_shift : hw_c;
	assign hdr_last  = (off_c == LW'(RECHDR_LAST));
	assign ll32      = {15'd0, length_limit};
	assign mask32    = {{(32-LW){1'b0}}, {LW{1'b1}}};
	assign lim32     = (ll32 < mask32) ? ll32 : mask32;
	assign over      = (hw_hdr > lim32);
	assign no_prior  = (lgood_c == '0);
	assign new_rlen  = over ? lgood_c : hw_hdr[LW-1:0];

	assign o_inc    = {1'b0, off_c} + (LW+1)'(1);
	assign rec_end  = (o_inc >= {1'b0, rlen_c});
	assign rec_last = (o_inc == {1'b0, rlen_c});
	assign type_bad = ({file_byte, hw_c[7:0]} != ETYPE_IPV4);
	assign in_pay   = (off_c >= LW'(OFF_PAYLOAD)) && (off_c < pend_c);
	assign pay_last = (o_inc == {1'b0, pend_c});

	// payload end = 42 + min(udp_len - 8, caplen - 42)
	assign udp_full = {udp_hi_c, file_byte};
	assign cnt16    = (udp_full < 16'(UDP_HDR_LEN)) ? 16'd0 : udp_full - 16'(UDP_HDR_LEN);
	assign cnt_w    = CW'(cnt16);
	assign avail_w  = CW'(rlen_c - LW'(OFF_PAYLOAD));
	assign clip_w   = (cnt_w > avail_w) ? avail_w : cnt_w;
	assign pend_new = LW'(OFF_PAYLOAD) + clip_w[LW-1:0];

	// next phase
	always_comb begin
		phase_d = phase_c;
		case (phase_c)
			PH_GLOBAL: begin
				if (glob_last)
					phase_d = glob_bad ? PH_HALT : PH_RECHDR;
			end
			PH_RECHDR: begin
				if (hdr_last) begin
					if (over && no_prior)
						phase_d = PH_HALT;
					else if (new_rlen != '0)
						phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rec_end)
					phase_d = PH_RECHDR;
			end
			default: phase_d = phase_c;
		endcase
	end

	// datapath and result
	always_comb begin
		off_d    = off_c;
		rlen_d   = rlen_c;
		lgood_d  = lgood_c;
		hw_d     = hw_c;
		udp_hi_d = udp_hi_c;
		ok_d     = ok_c;
		pend_d   = pend_c;
		res      = '{vld: 1'b0, kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0, code: CODE_SHORT};
		case (phase_c)
			PH_GLOBAL: begin
				hw_d  = hw_shift;
				off_d = off_c + LW'(1);
				if (glob_last) begin
					off_d = '0;
					if (glob_bad) begin
						res.vld  = 1'b1;
						res.kind = KIND_HALT;
						res.code = CODE_NOT_ETH;
					end else begin
						hw_d = '0;
					end
				end
			end
			PH_RECHDR: begin
				hw_d  = hw_hdr;
				off_d = off_c + LW'(1);
				if (hdr_last) begin
					off_d = '0;
					if (over && no_prior) begin
						res.vld  = 1'b1;
						res.kind = KIND_HALT;
						res.code = CODE_NO_PRIOR;
					end else begin
						hw_d   = '0;
						rlen_d = new_rlen;
						if (over) begin
							res.vld  = 1'b1;
							res.kind = KIND_SUBST;
						end else begin
							lgood_d = new_rlen;
						end
						if (new_rlen == '0) begin
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_SHORT;
						end else begin
							ok_d     = 1'b1;
							udp_hi_d = '0;
							pend_d   = '0;
						end
					end
				end
			end
			PH_DATA: begin
				if (ok_c) begin
					if (off_c == LW'(OFF_ETYPE_HI)) begin
						hw_d = {24'd0, file_byte};
					end else if (off_c == LW'(OFF_ETYPE_LO)) begin
						if (type_bad) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_NOT_IPV4;
						end else if (rlen_c < LW'(MIN_LEN_IP)) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_SHORT;
						end
					end else if (off_c == LW'(OFF_IP_VIHL)) begin
						hw_d = {24'd0, file_byte};
					end else if (off_c == LW'(OFF_IP_PROTO)) begin
						if (file_byte != PROTO_UDP) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_NOT_UDP;
						end else if (hw_c[3:0] != IHL_PLAIN) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_BAD_IHL;
						end else if (rlen_c < LW'(OFF_PAYLOAD)) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_DISCARD;
							res.code = CODE_SHORT;
						end
					end else if (off_c == LW'(OFF_UDP_HI)) begin
						udp_hi_d = file_byte;
					end else if (off_c == LW'(OFF_UDP_LO)) begin
						pend_d = pend_new;
					end else if (off_c == LW'(OFF_EMPTY)) begin
						if (pend_c == LW'(OFF_PAYLOAD)) begin
							ok_d     = 1'b0;
							res.vld  = 1'b1;
							res.kind = KIND_EMPTY;
						end
					end else if (in_pay) begin
						res.vld  = 1'b1;
						res.kind = KIND_PAYLOAD;
						res.data = file_byte;
						res.last = pay_last;
						if (pay_last)
							ok_d = 1'b0;
					end
					// record ran out before a verdict
					if (!res.vld && ok_d && rec_last) begin
						ok_d     = 1'b0;
						res.vld  = 1'b1;
						res.kind = KIND_DISCARD;
						res.code = CODE_SHORT;
					end
				end
				off_d = o_inc[LW-1:0];
				if (rec_end) begin
					off_d = '0;
					hw_d  = '0;
					ok_d  = 1'b0;
				end
			end
			default: begin
				// halted: bytes are dropped
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_GLOBAL;
			off_q    <= '0;
			rlen_q   <= '0;
			lgood_q  <= '0;
			hw_q     <= '0;
			udp_hi_q <= '0;
			ok_q     <= 1'b0;
			pend_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			off_q    <= off_d;
			rlen_q   <= rlen_d;
			lgood_q  <= lgood_d;
			hw_q     <= hw_d;
			udp_hi_q <= udp_hi_d;
			ok_q     <= ok_d;
			pend_q   <= pend_d;
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT && !restart) |-> !res.vld)
		else $error("result produced while halted");

	a_pend_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (pend_q <= rlen_q))
		else $error("payload end beyond record length");

	a_ok_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		ok_q |-> (phase_q == PH_DATA))
		else $error("packet_ok set outside record data");

endmodule

// ===== design/pcap_udp_payload_extractor.sv =====
// Top level: pcap byte stream in, UDP payload bytes and verdicts out.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | file_byte[7:0], restart
//  out      | out_valid/ out_ready | kind[2:0], payload_byte[7:0], last, code[2:0]
//  cfg      | cfg_valid/ cfg_ready | cfg_data[16:0] -> length_limit
//
// One byte per cycle sustained while out_ready stays high. A request is
// held in the input register, the parser steps over it and any result lands
// in the output register.
// The parser steps whenever the output register is empty or being drained,
// so a stall on out_ready backs up through in_ready with no bubble.
// Reset clears parser state and sets length_limit to 65536; cfg is always
// ready and should only be written while no request is in flight.
module pcap_udp_payload_extractor #(
	parameter int LENGTH_BITS = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        restart,
	// result stream
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last,
	output logic [2:0]  code,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);
	import pcapx_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        advance;
	result_t     res;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [2:0]  code_q;
	logic [16:0] length_limit_q;

	// parser consumes the staged byte when the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1    <= file_byte;
			restart_s1 <= restart;
		end
	end

	// length limit register; no backpressure on config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			length_limit_q <= LIMIT_RESET;
		else if (cfg_valid)
			length_limit_q <= cfg_data;
	end

	pcapx_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.file_byte    (byte_s1),
		.restart      (restart_s1),
		.length_limit (length_limit_q),
		.res          (res)
	);

	// output register: reloaded whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || out_ready)
			out_valid_q <= advance && res.vld;
	end

	always_ff @(posedge clk) begin
		if (advance && res.vld) begin
			kind_q <= res.kind;
			byte_q <= res.data;
			last_q <= res.last;
			code_q <= res.code;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = byte_q;
	assign last         = last_q;
	assign code         = code_q;

	a_non_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_PAYLOAD) |-> (byte_q == 8'd0 && !last_q))
		else $error("data or last set on a non-payload result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> (valid_s1 && $stable(byte_s1)))
		else $error("staged byte lost while output stalled");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (length_limit_q == $past(cfg_data)))
		else $error("length limit write not taken");

endmodule

// ===== tb/sv/pcap_udp_payload_extractor_test.sv =====
// Self-checking testbench for the pcap UDP payload extractor.
`timescale 1ns / 100ps

module pcap_udp_payload_extractor_test;
	import pcapx_pkg::*;

	// one byte of the capture file as the sender presents it
	typedef struct {
		logic [7:0] fbyte;
		logic       fresh;
	} feed_t;

	// one result as the parser should report it
	typedef struct {
		kind_t      sort;
		logic [7:0] value;
		logic       tail;
		code_t      reason;
	} outcome_t;

	localparam logic [31:0] PCAP_MAGIC  = 32'hA1B2_C3D4;
	localparam logic [15:0] IPV4_WIRE   = 16'h0800;  // ethertype bytes in wire order
	localparam int          STALL_LIMIT = 2000;      // cycles without any handshake
	localparam int          PHASE_BYTES = 125;       // random bytes per limit setting

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  file_byte = 8'h00;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic        last;
	logic [2:0]  code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = 17'd0;

	feed_t    file_stream[$];   // bytes waiting to be sent
	outcome_t due_results[$];   // predicted results not yet seen
	feed_t    head;
	int       mismatches = 0;
	int       cyc = 0;
	int       stall_cycles = 0;

	// Generator-side view of the parser, just enough to keep records framed.
	int unsigned gen_limit = LIMIT_RESET;
	int unsigned gen_good = 0;
	bit          gen_halted = 1'b0;
	int unsigned body_cap = 32'hFFFF_FFFF;   // lowered to cut a record short
	bit          corner_payload = 1'b0;      // payload bytes alternate 00 / FF

	// Parser model state, stepped once per accepted byte.
	phase_t      ph;
	logic [16:0] offs;
	logic [16:0] rec_len;
	logic [16:0] good_len;
	logic [16:0] pay_end;
	logic [16:0] lim_now;
	logic [31:0] word;
	logic [15:0] udp_len;
	logic        live;

	pcap_udp_payload_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.file_byte    (file_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last         (last),
		.code         (code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// Random idling on either side, except while bits 9:8 of the cycle count are both set.
	function automatic bit take_break();
		if ((cyc / 256) % 4 == 3)
			return 1'b0;
		return $urandom_range(0, 99) < 28;
	endfunction

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic void clear_parser();
		ph       = PH_GLOBAL;
		offs     = '0;
		rec_len  = '0;
		good_len = '0;
		pay_end  = '0;
		word     = '0;
		udp_len  = '0;
		live     = 1'b0;
	endfunction

	// The code field stays at zero (CODE_SHORT) for every kind but discard and halt.
	function automatic void owe(kind_t k, logic [7:0] d, logic l, code_t c);
		due_results.push_back('{k, d, l, c});
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic fresh);
		int unsigned o;
		int unsigned cnt;
		int unsigned room;
		bit          hit;
		hit = 1'b0;
		if (fresh)
			clear_parser();
		if (ph == PH_HALT)
			return;

		// 24-byte global header: only the link type in the last word matters
		if (ph == PH_GLOBAL) begin
			word = {b, word[31:8]};
			if (offs == GLOBAL_LAST) begin
				offs = '0;
				if (word != LINKTYPE_ETH) begin
					ph = PH_HALT;
					owe(KIND_HALT, 8'h00, 1'b0, CODE_NOT_ETH);
				end else begin
					word = '0;
					ph = PH_RECHDR;
				end
			end else begin
				offs++;
			end
			return;
		end

		// 16-byte record header: captured length little-endian in bytes 8..11
		if (ph == PH_RECHDR) begin
			if (offs >= CAPLEN_FIRST && offs <= CAPLEN_LAST)
				word = {b, word[31:8]};
			if (offs != RECHDR_LAST) begin
				offs++;
				return;
			end
			offs = '0;
			if (word > lim_now) begin
				// oversize: fall back on the last accepted length, or give up
				if (good_len == 0) begin
					ph = PH_HALT;
					owe(KIND_HALT, 8'h00, 1'b0, CODE_NO_PRIOR);
					return;
				end
				rec_len = good_len;
				owe(KIND_SUBST, 8'h00, 1'b0, CODE_SHORT);
			end else begin
				rec_len  = word[16:0];
				good_len = word[16:0];
			end
			word = '0;
			if (rec_len == 0) begin
				owe(KIND_DISCARD, 8'h00, 1'b0, CODE_SHORT);
				return;
			end
			ph      = PH_DATA;
			live    = 1'b1;
			udp_len = '0;
			pay_end = '0;
			return;
		end

		// record data: checks in file order, then the payload bytes
		o = offs;
		if (live) begin
			if (o == OFF_ETYPE_HI) begin
				word = {24'h0, b};
			end else if (o == OFF_ETYPE_LO) begin
				if ({b, word[7:0]} != ETYPE_IPV4) begin
					live = 1'b0;
					hit  = 1'b1;
					owe(KIND_DISCARD, 8'h00, 1'b0, CODE_NOT_IPV4);
				end else if (rec_len < MIN_LEN_IP) begin
					live = 1'b0;
					hit  = 1'b1;
					owe(KIND_DISCARD, 8'h00, 1'b0, CODE_SHORT);
				end
			end else if (o == OFF_IP_VIHL) begin
				word = {24'h0, b};
			end else if (o == OFF_IP_PROTO) begin
				live = 1'b0;
				hit  = 1'b1;
				if (b != PROTO_UDP)
					owe(KIND_DISCARD, 8'h00, 1'b0, CODE_NOT_UDP);
				else if (word[3:0] != IHL_PLAIN)
					owe(KIND_DISCARD, 8'h00, 1'b0, CODE_BAD_IHL);
				else if (rec_len < OFF_PAYLOAD)
					owe(KIND_DISCARD, 8'h00, 1'b0, CODE_SHORT);
				else begin
					live = 1'b1;
					hit  = 1'b0;
				end
			end else if (o == OFF_UDP_HI) begin
				udp_len = {b, 8'h00};
			end else if (o == OFF_UDP_LO) begin
				udp_len = udp_len | {8'h00, b};
				cnt = (udp_len < UDP_HDR_LEN) ? 0 : udp_len - UDP_HDR_LEN;
				room = rec_len - OFF_PAYLOAD;
				if (cnt > room)
					cnt = room;   // never read past the captured bytes
				pay_end = 17'(OFF_PAYLOAD + cnt);
			end else if (o == OFF_EMPTY) begin
				if (pay_end == OFF_PAYLOAD) begin
					live = 1'b0;
					hit  = 1'b1;
					owe(KIND_EMPTY, 8'h00, 1'b0, CODE_SHORT);
				end
			end else if (o >= OFF_PAYLOAD && o < pay_end) begin
				hit = 1'b1;
				if (o + 1 == pay_end)
					live = 1'b0;
				owe(KIND_PAYLOAD, b, (o + 1 == pay_end), CODE_SHORT);
			end
			// record ended before any verdict
			if (!hit && live && o + 1 == rec_len) begin
				live = 1'b0;
				owe(KIND_DISCARD, 8'h00, 1'b0, CODE_SHORT);
			end
		end
		offs = 17'(o + 1);
		if (o + 1 >= rec_len) begin
			ph   = PH_RECHDR;
			offs = '0;
			word = '0;
			live = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// File builders
	// ------------------------------------------------------------------

	task automatic push_byte(input logic [7:0] b, input logic fresh);
		file_stream.push_back('{b, fresh});
	endtask

	task automatic push_global(input logic [31:0] link, input logic fresh);
		logic [7:0] v;
		for (int i = 0; i <= GLOBAL_LAST; i++) begin
			if (i < 4)
				v = PCAP_MAGIC[8*i +: 8];
			else if (i > GLOBAL_LAST - 4)
				v = link[8*(i - (GLOBAL_LAST - 3)) +: 8];
			else
				v = 8'($urandom);
			push_byte(v, fresh && i == 0);
		end
		gen_good   = 0;
		gen_halted = (link != LINKTYPE_ETH);
	endtask

	// Header with the given captured length, then as many data bytes as the
	// parser will frame: the length itself, or the fallback when oversize.
	task automatic push_record(input logic [31:0] caplen, input logic [15:0] etype,
			input logic [7:0] vihl, input logic [7:0] proto, input logic [15:0] udp);
		int unsigned body;
		logic [7:0]  v;
		for (int i = 0; i <= RECHDR_LAST; i++) begin
			if (i >= CAPLEN_FIRST && i <= CAPLEN_LAST)
				v = caplen[8*(i - CAPLEN_FIRST) +: 8];
			else
				v = 8'($urandom);
			push_byte(v, 1'b0);
		end
		if (caplen > gen_limit) begin
			if (gen_good == 0) begin
				gen_halted = 1'b1;
				return;
			end
			body = gen_good;
		end else begin
			body     = caplen;
			gen_good = caplen;
		end
		if (body > body_cap)
			body = body_cap;
		for (int i = 0; i < body; i++) begin
			case (i)
			OFF_ETYPE_HI: v = etype[15:8];
			OFF_ETYPE_LO: v = etype[7:0];
			OFF_IP_VIHL:  v = vihl;
			OFF_IP_PROTO: v = proto;
			OFF_UDP_HI:   v = udp[15:8];
			OFF_UDP_LO:   v = udp[7:0];
			default:      v = corner_payload ? {8{i[0]}} : 8'($urandom);
			endcase
			push_byte(v, 1'b0);
		end
	endtask

	// Mostly good UDP frames with random content; the rest broken or noise.
	task automatic push_random_packet();
		int unsigned pick;
		int unsigned count;
		int unsigned len;
		logic [15:0] udp;
		logic [31:0] link;
		pick = $urandom_range(0, 99);
		if (gen_halted) begin
			// bytes sent while halted are dropped until the next restart
			repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
			push_global(LINKTYPE_ETH, 1'b1);
		end else if (pick < 60) begin
			count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 20);
			len = OFF_PAYLOAD + count + $urandom_range(0, 3);
			case ($urandom_range(0, 7))
			0:       udp = 16'($urandom_range(0, 7));
			1:       udp = 16'hFFFF;
			default: udp = 16'(count + UDP_HDR_LEN);
			endcase
			push_record(len, IPV4_WIRE, {4'($urandom), IHL_PLAIN}, PROTO_UDP, udp);
		end else if (pick < 80) begin
			len = $urandom_range(0, 60);
			case ($urandom_range(0, 3))
			0: push_record(len, 16'($urandom), {4'($urandom), IHL_PLAIN}, PROTO_UDP, 16'd20);
			1: push_record(len, IPV4_WIRE, {4'($urandom), IHL_PLAIN}, 8'($urandom), 16'd20);
			2: push_record(len, IPV4_WIRE, 8'($urandom), PROTO_UDP, 16'd20);
			default: push_record(len, IPV4_WIRE, {4'($urandom), IHL_PLAIN}, PROTO_UDP,
					16'($urandom_range(0, 40)));
			endcase
		end else if (pick < 88) begin
			len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : gen_limit + $urandom_range(1, 300);
			push_record(len, IPV4_WIRE, {4'($urandom), IHL_PLAIN}, PROTO_UDP,
					16'($urandom_range(0, 30)));
		end else if (pick < 95) begin
			push_record($urandom_range(0, 64), 16'($urandom), 8'($urandom), 8'($urandom),
					16'($urandom));
		end else begin
			link = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(2, 300)) : LINKTYPE_ETH;
			push_global(link, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Hold off until the sender is empty and every predicted result is in,
	// then give the two-stage pipe time to settle on records with no result.
	task automatic wait_drain();
		while (file_stream.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [16:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		lim_now   = v;
		gen_limit = v;
	endtask

	task automatic check_outcome();
		outcome_t w;
		if (due_results.size() == 0) begin
			report_error($sformatf("result kind %0d code %0d with nothing outstanding",
					kind, code));
			return;
		end
		w = due_results.pop_front();
		if (kind !== w.sort)
			report_error($sformatf("kind %0d, expected %0d", kind, w.sort));
		if (payload_byte !== w.value)
			report_error($sformatf("payload_byte %02h, expected %02h", payload_byte, w.value));
		if (last !== w.tail)
			report_error($sformatf("last %0b, expected %0b", last, w.tail));
		if (code !== w.reason)
			report_error($sformatf("code %0d, expected %0d", code, w.reason));
	endtask

	// ------------------------------------------------------------------
	// Driver: pulls bytes from file_stream, holds each until accepted.
	// The model steps on the accepted byte at the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				parse_byte(file_byte, restart);
			if (!in_valid || in_ready) begin
				if (file_stream.size() != 0 && !take_break()) begin
					head = file_stream.pop_front();
					in_valid  <= 1'b1;
					file_byte <= head.fbyte;
					restart   <= head.fresh;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction and
	// throttles out_ready at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_outcome();
			out_ready <= !take_break();
		end
	end

	// Cycle count for the idle pattern, and a watchdog on handshake progress.
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == STALL_LIMIT) begin
				$display("[%0t] ERROR: no request moved for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [16:0] limit_plan [4];
		limit_plan = '{17'd1, 17'd45, 17'($urandom_range(60, 65535)), LIMIT_RESET};
		lim_now = LIMIT_RESET;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_limit(LIMIT_RESET);

		// wrong link type halts; bytes after that are dropped
		push_global(32'd2, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_global(LINKTYPE_ETH, 1'b1);
		// oversize length with nothing to fall back on
		push_record(32'h00FF_FFFF, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		push_global(LINKTYPE_ETH, 1'b1);
		// empty record, then one too short for an Ethernet header
		push_record(32'd0, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		push_record(32'd10, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		// IPv4 but too short for an IP header
		push_record(32'd30, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		// each header check failing on its own
		push_record(32'd60, 16'h86DD, 8'h45, PROTO_UDP, 16'd9);
		push_record(32'd60, IPV4_WIRE, 8'h45, 8'd6, 16'd9);
		push_record(32'd60, IPV4_WIRE, 8'h46, PROTO_UDP, 16'd9);
		// UDP but too short for a UDP header
		push_record(32'd40, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		// empty payloads: UDP length of exactly 8, below 8, nothing captured
		push_record(32'd50, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd8);
		push_record(32'd50, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd3);
		push_record(32'd42, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd20);
		// maximum UDP length clipped to the capture, payload bytes 00 / FF
		corner_payload = 1'b1;
		push_record(32'd50, IPV4_WIRE, 8'h45, PROTO_UDP, 16'hFFFF);
		corner_payload = 1'b0;
		// normal payload with trailing bytes, then a fallback length
		push_record(32'd60, IPV4_WIRE, 8'hF5, PROTO_UDP, 16'd13);
		push_record(32'hFFFF_FFFF, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		// restart in the middle of a record
		body_cap = 20;
		push_record(32'd60, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd13);
		body_cap = 32'hFFFF_FFFF;
		push_global(LINKTYPE_ETH, 1'b1);
		push_record(32'd43, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
		wait_drain();

		// random traffic under several limits; each write waits for a drained pipe
		for (int p = 0; p < 4; p++) begin
			write_limit(limit_plan[p]);
			if (limit_plan[p] == 17'd1) begin
				push_record(32'd1, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
				push_record(32'd2, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd9);
			end else if (limit_plan[p] == 17'd45) begin
				// right at the limit, then one over it
				push_record(32'd45, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd11);
				push_record(32'd46, IPV4_WIRE, 8'h45, PROTO_UDP, 16'd12);
			end
			while (file_stream.size() < PHASE_BYTES)
				push_random_packet();
			wait_drain();
		end

		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
